### design/fif_pkg.sv
// ----------------------------------------------------------------------------
// fif_pkg
// Shared types, constants and the control store for the integer field
// formatter.
// ----------------------------------------------------------------------------
package fif_pkg;

  localparam logic [5:0] MAX_FIELD  = 6'd48;
  localparam int         NUM_DIGITS = 22;
  localparam int         DIG_BITS   = 4 * NUM_DIGITS;
  localparam int         NUM_STEPS  = 16;
  localparam int         PC_BITS    = $clog2(NUM_STEPS);

  localparam logic [7:0]   CH_SPACE  = 8'h20;
  localparam logic [7:0]   CH_ZERO   = 8'h30;
  localparam logic [7:0]   CH_PLUS   = 8'h2B;
  localparam logic [7:0]   CH_MINUS  = 8'h2D;
  localparam logic [7:0]   CH_LOW_X  = 8'h78;
  localparam logic [7:0]   CH_UP_X   = 8'h58;
  localparam logic [7:0]   CASE_BIT  = 8'h20;
  localparam logic [127:0] HEX_CHARS = "0123456789ABCDEF";

  typedef enum logic [2:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_OCT  = 3'd2,
    OP_LHEX = 3'd3,
    OP_UHEX = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ACT_LOAD,
    ACT_SIGN,
    ACT_PREP,
    ACT_DABBLE,
    ACT_STRIP,
    ACT_CALC1,
    ACT_CALC2,
    ACT_CALC3,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    SRC_SPACE,
    SRC_SIGN,
    SRC_ZERO,
    SRC_PFX,
    SRC_DIGIT
  } src_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_IN,
    C_BAD,
    C_NDEC,
    C_CNT,
    C_STRIP,
    C_EMIT,
    C_DONE
  } cond_t;

  typedef enum logic [3:0] {
    LD_KEEP,
    LD_BITS,
    LD_PADL,
    LD_SIGN,
    LD_PFX,
    LD_PADZ,
    LD_ZEROS,
    LD_DIGITS,
    LD_PADR
  } ld_t;

  typedef struct packed {
    act_t               act;
    src_t               src;
    cond_t              cond;
    ld_t                ld;
    logic [PC_BITS-1:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic bad;
    logic is_dec;
    logic cnt_zero;
    logic cnt_one;
    logic fire;
    logic strip_more;
  } stat_t;

  localparam logic [PC_BITS-1:0] STEP_WAIT  = PC_BITS'(0);
  localparam logic [PC_BITS-1:0] STEP_STRIP = PC_BITS'(4);

  localparam ctrl_t UCODE [NUM_STEPS] = '{
    '{ACT_LOAD,   SRC_SPACE, C_IN,    LD_KEEP,   STEP_WAIT},
    '{ACT_SIGN,   SRC_SPACE, C_BAD,   LD_KEEP,   STEP_WAIT},
    '{ACT_PREP,   SRC_SPACE, C_NDEC,  LD_BITS,   STEP_STRIP},
    '{ACT_DABBLE, SRC_SPACE, C_CNT,   LD_KEEP,   STEP_WAIT},
    '{ACT_STRIP,  SRC_SPACE, C_STRIP, LD_KEEP,   STEP_WAIT},
    '{ACT_CALC1,  SRC_SPACE, C_NEXT,  LD_KEEP,   STEP_WAIT},
    '{ACT_CALC2,  SRC_SPACE, C_NEXT,  LD_KEEP,   STEP_WAIT},
    '{ACT_CALC3,  SRC_SPACE, C_NEXT,  LD_PADL,   STEP_WAIT},
    '{ACT_EMIT,   SRC_SPACE, C_EMIT,  LD_SIGN,   STEP_WAIT},
    '{ACT_EMIT,   SRC_SIGN,  C_EMIT,  LD_PFX,    STEP_WAIT},
    '{ACT_EMIT,   SRC_ZERO,  C_EMIT,  LD_PFX,    STEP_WAIT},
    '{ACT_EMIT,   SRC_PFX,   C_EMIT,  LD_PADZ,   STEP_WAIT},
    '{ACT_EMIT,   SRC_ZERO,  C_EMIT,  LD_ZEROS,  STEP_WAIT},
    '{ACT_EMIT,   SRC_ZERO,  C_EMIT,  LD_DIGITS, STEP_WAIT},
    '{ACT_EMIT,   SRC_DIGIT, C_EMIT,  LD_PADR,   STEP_WAIT},
    '{ACT_EMIT,   SRC_SPACE, C_DONE,  LD_KEEP,   STEP_WAIT}
  };

endpackage

### design/fif_sequencer.sv
// ----------------------------------------------------------------------------
// fif_sequencer
// Step counter and control store; picks the next step from the branch
// condition of the current control word.
// ----------------------------------------------------------------------------
module fif_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  fif_pkg::stat_t stat,
  output fif_pkg::ctrl_t ctrl,
  output logic           advance
);
  import fif_pkg::*;

  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] pc_next;
  logic [PC_BITS-1:0] pc_inc;

  assign ctrl   = UCODE[pc];
  assign pc_inc = pc + PC_BITS'(1);

  always_comb begin
    pc_next = pc;
    unique case (ctrl.cond)
      C_NEXT:  pc_next = pc_inc;
      C_IN:    if (stat.accept) pc_next = pc_inc;
      C_BAD:   pc_next = stat.bad ? ctrl.tgt : pc_inc;
      C_NDEC:  pc_next = stat.is_dec ? pc_inc : ctrl.tgt;
      C_CNT:   if (stat.cnt_zero) pc_next = pc_inc;
      C_STRIP: if (!stat.strip_more) pc_next = pc_inc;
      C_EMIT:  if (stat.cnt_zero || (stat.cnt_one && stat.fire)) pc_next = pc_inc;
      C_DONE:  if (stat.cnt_zero || (stat.cnt_one && stat.fire)) pc_next = ctrl.tgt;
      default: pc_next = STEP_WAIT;
    endcase
  end

  assign advance = (pc_next != pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### design/fif_datapath.sv
// ----------------------------------------------------------------------------
// fif_datapath
// Operand registers, sign and magnitude, digit register with binary to BCD
// shifting, field length arithmetic, segment counter and output register.
// ----------------------------------------------------------------------------
module fif_datapath (
  input  logic              clk,
  input  logic              rst,
  input  fif_pkg::ctrl_t    ctrl,
  input  logic              advance,
  output fif_pkg::stat_t    stat,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        op,
  input  logic [63:0]       value,
  input  logic [1:0]        arg_size,
  input  logic              left_justify,
  input  logic              force_plus,
  input  logic              space_sign,
  input  logic              alternate,
  input  logic              zero_pad,
  input  logic [5:0]        width,
  input  logic signed [6:0] precision,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char,
  output logic              last,
  output logic [5:0]        total_length
);
  import fif_pkg::*;

  localparam int OCT_BITS = 3 * NUM_DIGITS;

  logic [2:0]          op_r;
  logic [1:0]          size_r;
  logic                left_r;
  logic                plus_r;
  logic                space_r;
  logic                alt_r;
  logic                zpad_r;
  logic [5:0]          wid_r;
  logic [5:0]          prec_r;
  logic                pg_r;
  logic [63:0]         value_r;
  logic [63:0]         mag;
  logic                sign_en;
  logic [7:0]          sign_ch;
  logic [63:0]         sh;
  logic [DIG_BITS-1:0] dig;
  logic [4:0]          nd;
  logic [6:0]          cnt;
  logic [5:0]          zeros;
  logic                pfx_en;
  logic [6:0]          len;
  logic [5:0]          pad;
  logic [5:0]          rem;
  logic [5:0]          tot;

  logic                accept;
  logic                fire;
  logic [63:0]         mask;
  logic                sbit;
  logic [63:0]         masked;
  logic                neg;
  logic [6:0]          bits;
  logic [63:0]         sh_init;
  logic [OCT_BITS-1:0] magx;
  logic [DIG_BITS-1:0] dig_oct;
  logic [DIG_BITS-1:0] dig_adj;
  logic [3:0]          top;
  logic [7:0]          dch;
  logic [7:0]          ch;
  logic                pad_lead;
  logic                pad_zero;
  logic [6:0]          seg_len;
  logic [5:0]          tot_calc;

  function automatic logic [DIG_BITS-1:0] bcd_adjust(input logic [DIG_BITS-1:0] d);
    logic [DIG_BITS-1:0] r;
    r = d;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (d[4*i +: 4] >= 4'd5) r[4*i +: 4] = d[4*i +: 4] + 4'd3;
    end
    return r;
  endfunction

  function automatic logic [6:0] len_sum(input logic [4:0] n, input logic [5:0] z,
                                         input logic s, input logic p);
    return {2'd0, n} + {1'b0, z} + {6'd0, s} + {5'd0, p, 1'b0};
  endfunction

  assign in_stall = (ctrl.act != ACT_LOAD);
  assign accept   = in_valid && !in_stall;
  assign fire     = (ctrl.act == ACT_EMIT) && (cnt != 7'd0) && (!out_valid || !out_stall);
  assign top      = dig[DIG_BITS-1 -: 4];
  assign dig_adj  = bcd_adjust(dig);

  assign stat.accept     = accept;
  assign stat.bad        = (op_r > OP_UHEX);
  assign stat.is_dec     = (op_r == OP_SDEC) || (op_r == OP_UDEC);
  assign stat.cnt_zero   = (cnt == 7'd0);
  assign stat.cnt_one    = (cnt == 7'd1);
  assign stat.fire       = fire;
  assign stat.strip_more = (nd != 5'd0) && (top == 4'd0);

  always_comb begin
    unique case (size_r)
      2'd0: begin
        mask    = 64'h0000_0000_0000_00FF;
        sbit    = value_r[7];
        bits    = 7'd8;
        sh_init = {mag[7:0], 56'd0};
      end
      2'd1: begin
        mask    = 64'h0000_0000_0000_FFFF;
        sbit    = value_r[15];
        bits    = 7'd16;
        sh_init = {mag[15:0], 48'd0};
      end
      2'd2: begin
        mask    = 64'h0000_0000_FFFF_FFFF;
        sbit    = value_r[31];
        bits    = 7'd32;
        sh_init = {mag[31:0], 32'd0};
      end
      default: begin
        mask    = 64'hFFFF_FFFF_FFFF_FFFF;
        sbit    = value_r[63];
        bits    = 7'd64;
        sh_init = mag;
      end
    endcase
  end

  assign masked = value_r & mask;
  assign neg    = (op_r == OP_SDEC) && sbit;
  assign magx   = {(OCT_BITS - 64)'(0), mag};

  always_comb begin
    dig_oct = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig_oct[4*i +: 4] = {1'b0, magx[3*i +: 3]};
    end
  end

  always_comb begin
    if (stat.is_dec || op_r == OP_OCT) begin
      dch = CH_ZERO + {4'd0, top};
    end else begin
      dch = HEX_CHARS[{~top, 3'b000} +: 8] | ((op_r == OP_LHEX) ? CASE_BIT : 8'h00);
    end
  end

  always_comb begin
    unique case (ctrl.src)
      SRC_SPACE: ch = CH_SPACE;
      SRC_SIGN:  ch = sign_ch;
      SRC_ZERO:  ch = CH_ZERO;
      SRC_PFX:   ch = (op_r == OP_LHEX) ? CH_LOW_X : CH_UP_X;
      SRC_DIGIT: ch = dch;
      default:   ch = CH_SPACE;
    endcase
  end

  assign pad_lead = !left_r && !(zpad_r && !pg_r);
  assign pad_zero = !left_r && zpad_r && !pg_r;

  always_comb begin
    unique case (ctrl.ld)
      LD_BITS:   seg_len = bits;
      LD_PADL:   seg_len = pad_lead ? {1'b0, pad} : 7'd0;
      LD_SIGN:   seg_len = {6'd0, sign_en};
      LD_PFX:    seg_len = {6'd0, pfx_en};
      LD_PADZ:   seg_len = pad_zero ? {1'b0, pad} : 7'd0;
      LD_ZEROS:  seg_len = {1'b0, zeros};
      LD_DIGITS: seg_len = {2'd0, nd};
      LD_PADR:   seg_len = left_r ? {1'b0, pad} : 7'd0;
      default:   seg_len = cnt;
    endcase
  end

  assign tot_calc = 6'(len + {1'b0, pad});

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op;
      size_r  <= arg_size;
      left_r  <= left_justify;
      plus_r  <= force_plus;
      space_r <= space_sign;
      alt_r   <= alternate;
      zpad_r  <= zero_pad;
      value_r <= value;
      wid_r   <= (width > MAX_FIELD) ? MAX_FIELD : width;
      pg_r    <= !precision[6];
      if (precision[6]) begin
        prec_r <= 6'd1;
      end else begin
        prec_r <= (precision[5:0] > MAX_FIELD) ? MAX_FIELD : precision[5:0];
      end
    end

    unique case (ctrl.act)
      ACT_SIGN: begin
        mag     <= neg ? ((~masked + 64'd1) & mask) : masked;
        sign_en <= neg || ((op_r == OP_SDEC) && (plus_r || space_r));
        sign_ch <= neg ? CH_MINUS : (plus_r ? CH_PLUS : CH_SPACE);
      end
      ACT_PREP: begin
        nd <= 5'(NUM_DIGITS);
        sh <= sh_init;
        if (stat.is_dec) begin
          dig <= '0;
        end else if (op_r == OP_OCT) begin
          dig <= dig_oct;
        end else begin
          dig <= {(DIG_BITS - 64)'(0), mag};
        end
      end
      ACT_DABBLE: begin
        if (cnt != 7'd0) begin
          dig <= {dig_adj[DIG_BITS-2:0], sh[63]};
          sh  <= {sh[62:0], 1'b0};
        end
      end
      ACT_STRIP: begin
        if (stat.strip_more) begin
          dig <= {dig[DIG_BITS-5:0], 4'd0};
          nd  <= nd - 5'd1;
        end
      end
      ACT_CALC1: begin
        pfx_en <= ((op_r == OP_LHEX) || (op_r == OP_UHEX)) && alt_r && (nd != 5'd0);
        if (prec_r > {1'b0, nd}) begin
          zeros <= prec_r - {1'b0, nd};
        end else begin
          zeros <= {5'd0, (op_r == OP_OCT) && alt_r};
        end
      end
      ACT_CALC2: begin
        len <= {2'd0, nd} + {1'b0, zeros} + {6'd0, sign_en} + {5'd0, pfx_en, 1'b0};
        pad <= ({1'b0, wid_r} > len_sum(nd, zeros, sign_en, pfx_en)) ?
               6'({1'b0, wid_r} - len_sum(nd, zeros, sign_en, pfx_en)) : 6'd0;
      end
      ACT_CALC3: begin
        tot <= tot_calc;
        rem <= tot_calc;
      end
      ACT_EMIT: begin
        if (fire) begin
          rem <= rem - 6'd1;
          if (ctrl.src == SRC_DIGIT) dig <= {dig[DIG_BITS-5:0], 4'd0};
        end
      end
      default: begin
      end
    endcase

    if (fire) begin
      out_char     <= ch;
      last         <= (rem == 6'd1);
      total_length <= (rem == 6'd1) ? tot : 6'd0;
    end

    if (rst) begin
      cnt       <= 7'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance && ctrl.ld != LD_KEEP) begin
        cnt <= seg_len;
      end else if (((ctrl.act == ACT_DABBLE) && (cnt != 7'd0)) || fire) begin
        cnt <= cnt - 7'd1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/format_integer_field.sv
// ----------------------------------------------------------------------------
// format_integer_field
// One printf-style integer conversion per transfer, emitted as a stream of
// ASCII characters with the last one marked and carrying the field length.
// ----------------------------------------------------------------------------
// Sequence: after the input transfer the operand is masked to its size and split
//   into sign and magnitude, decimal values are shifted into BCD, leading zeros
//   are stripped from the 22-digit register, the field lengths are computed and
//   the eight segments are stepped through, empty ones included. One item at a
//   time: a new item is not accepted until the previous field has been emitted.
// Reset: rst returns the step counter to the wait step and empties the output.
module format_integer_field (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        op,
  input  logic [63:0]       value,
  input  logic [1:0]        arg_size,
  input  logic              left_justify,
  input  logic              force_plus,
  input  logic              space_sign,
  input  logic              alternate,
  input  logic              zero_pad,
  input  logic [5:0]        width,
  input  logic signed [6:0] precision,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char,
  output logic              last,
  output logic [5:0]        total_length
);
  import fif_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  advance;

  fif_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .stat    (stat),
    .ctrl    (ctrl),
    .advance (advance)
  );

  fif_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .advance      (advance),
    .stat         (stat),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .value        (value),
    .arg_size     (arg_size),
    .left_justify (left_justify),
    .force_plus   (force_plus),
    .space_sign   (space_sign),
    .alternate    (alternate),
    .zero_pad     (zero_pad),
    .width        (width),
    .precision    (precision),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .last         (last),
    .total_length (total_length)
  );

endmodule
